@@ rtl/xood_pkg.sv @@
package xood_pkg;

  localparam int unsigned LANE_W     = 32;
  localparam int unsigned NUM_LANES  = 12;
  localparam int unsigned NUM_ROUNDS = 12;
  localparam int unsigned RCNT_W     = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // register index codes, taken from paddr[2]
  localparam logic REG_ROUND_COUNT = 1'b0;

  localparam logic [RCNT_W-1:0] ROUND_COUNT_RST = RCNT_W'(NUM_ROUNDS);

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

  // per-stage round select: whether the stage applies its round, and its constant
  typedef struct packed {
    logic  active;
    lane_t rc;
  } round_sel_t;

  localparam lane_t RC_TABLE [NUM_ROUNDS] = '{
    32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
    32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
    32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
  };

  function automatic lane_t rotl(lane_t v, int unsigned r);
    return (v << r) | (v >> (LANE_W - r));
  endfunction

  // one full round: theta, rho-west, iota, chi, rho-east
  function automatic lanes_t xood_round(lanes_t a, lane_t rc);
    lane_t  p [4];
    lane_t  e [4];
    lanes_t th;
    lanes_t w;
    lanes_t c;
    lanes_t r;
    for (int x = 0; x < 4; x++) begin
      p[x] = a[x] ^ a[4+x] ^ a[8+x];
    end
    for (int x = 0; x < 4; x++) begin
      e[x] = rotl(p[(x+3) & 3], 5) ^ rotl(p[(x+3) & 3], 14);
    end
    for (int i = 0; i < 12; i++) begin
      th[i] = a[i] ^ e[i & 3];
    end
    for (int x = 0; x < 4; x++) begin
      w[x]   = th[x];
      w[4+x] = th[4 + ((x+3) & 3)];
      w[8+x] = rotl(th[8+x], 11);
    end
    w[0] = w[0] ^ rc;
    for (int x = 0; x < 4; x++) begin
      c[x]   = w[x]   ^ (~w[4+x] & w[8+x]);
      c[4+x] = w[4+x] ^ (~w[8+x] & w[x]);
      c[8+x] = w[8+x] ^ (~w[x]   & w[4+x]);
    end
    for (int x = 0; x < 4; x++) begin
      r[x]   = c[x];
      r[4+x] = rotl(c[4+x], 1);
      r[8+x] = rotl(c[8 + ((x+2) & 3)], 8);
    end
    return r;
  endfunction

endpackage

@@ rtl/xood_in_if.sv @@
interface xood_in_if import xood_pkg::*;;
  logic  valid;
  logic  ready;
  lane_t lane_in_0;
  lane_t lane_in_1;
  lane_t lane_in_2;
  lane_t lane_in_3;
  lane_t lane_in_4;
  lane_t lane_in_5;
  lane_t lane_in_6;
  lane_t lane_in_7;
  lane_t lane_in_8;
  lane_t lane_in_9;
  lane_t lane_in_10;
  lane_t lane_in_11;

  modport source (
    output valid, lane_in_0, lane_in_1, lane_in_2, lane_in_3, lane_in_4, lane_in_5,
           lane_in_6, lane_in_7, lane_in_8, lane_in_9, lane_in_10, lane_in_11,
    input  ready
  );
  modport sink (
    input  valid, lane_in_0, lane_in_1, lane_in_2, lane_in_3, lane_in_4, lane_in_5,
           lane_in_6, lane_in_7, lane_in_8, lane_in_9, lane_in_10, lane_in_11,
    output ready
  );
endinterface

@@ rtl/xood_out_if.sv @@
interface xood_out_if import xood_pkg::*;;
  logic  valid;
  logic  ready;
  lane_t lane_out_0;
  lane_t lane_out_1;
  lane_t lane_out_2;
  lane_t lane_out_3;
  lane_t lane_out_4;
  lane_t lane_out_5;
  lane_t lane_out_6;
  lane_t lane_out_7;
  lane_t lane_out_8;
  lane_t lane_out_9;
  lane_t lane_out_10;
  lane_t lane_out_11;

  modport source (
    output valid, lane_out_0, lane_out_1, lane_out_2, lane_out_3, lane_out_4,
           lane_out_5, lane_out_6, lane_out_7, lane_out_8, lane_out_9,
           lane_out_10, lane_out_11,
    input  ready
  );
  modport sink (
    input  valid, lane_out_0, lane_out_1, lane_out_2, lane_out_3, lane_out_4,
           lane_out_5, lane_out_6, lane_out_7, lane_out_8, lane_out_9,
           lane_out_10, lane_out_11,
    output ready
  );
endinterface

@@ rtl/xood_round_stage.sv @@
module xood_round_stage
  import xood_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  round_sel_t sel,
  input  logic       up_valid,
  output logic       up_ready,
  input  lanes_t     up_lanes,
  output logic       dn_valid,
  input  logic       dn_ready,
  output lanes_t     dn_lanes
);

  logic   valid_r;
  lanes_t lanes_r;
  lanes_t lanes_nxt;

  // stage can load when empty or when its content moves on this cycle
  assign up_ready = !valid_r || dn_ready;

  assign lanes_nxt = sel.active ? xood_round(up_lanes, sel.rc) : up_lanes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lanes = lanes_r;

endmodule

@@ rtl/xoodoo_permutation_unit.sv @@
// Xoodoo 384-bit permutation, fully unrolled.
//
// in_beat  : one beat carries a whole state, twelve 32-bit lanes (plane 0 is
//            lanes 0-3, plane 1 lanes 4-7, plane 2 lanes 8-11).
// out_beat : one beat per input beat, the permuted state in the same layout,
//            in input order.
// APB port : register 0 at byte address 0 is round_count (4 bits, reset 12).
//            Values above 12 act as 12; 0 passes the state through unchanged.
//            With N rounds the last N round constants are used.
//            Write it only while the pipeline is empty.
//
// From the input beat to the output beat the state passes twelve round
// stages, one register each, each stage holding one round (theta, rho-west,
// iota, chi, rho-east). Stages whose round is not selected just carry the
// state, so latency does not depend on round_count.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous) empties every stage and sets round_count to 12.
// When the receiver stalls, the last stage holds its beat and the stages
// behind it keep filling; in_beat.ready drops only when all twelve are full.
module xoodoo_permutation_unit
  import xood_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  xood_in_if.sink               in_beat,
  xood_out_if.source            out_beat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RCNT_W-1:0] round_count_r;
  logic [RCNT_W-1:0] rounds_sat;
  logic              reg_hit;

  logic   stg_valid [NUM_ROUNDS+1];
  logic   stg_ready [NUM_ROUNDS+1];
  lanes_t stg_lanes [NUM_ROUNDS+1];

  // ---- configuration ----
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_ROUND_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= ROUND_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      round_count_r <= pwdata[RCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(CFG_DATA_W-RCNT_W){1'b0}}, round_count_r};
    end
  end

  // counts above the table saturate
  assign rounds_sat = (round_count_r > ROUND_COUNT_RST) ? ROUND_COUNT_RST : round_count_r;

  // ---- input unpack ----
  assign stg_valid[0]    = in_beat.valid;
  assign in_beat.ready   = stg_ready[0];
  assign stg_lanes[0][0]  = in_beat.lane_in_0;
  assign stg_lanes[0][1]  = in_beat.lane_in_1;
  assign stg_lanes[0][2]  = in_beat.lane_in_2;
  assign stg_lanes[0][3]  = in_beat.lane_in_3;
  assign stg_lanes[0][4]  = in_beat.lane_in_4;
  assign stg_lanes[0][5]  = in_beat.lane_in_5;
  assign stg_lanes[0][6]  = in_beat.lane_in_6;
  assign stg_lanes[0][7]  = in_beat.lane_in_7;
  assign stg_lanes[0][8]  = in_beat.lane_in_8;
  assign stg_lanes[0][9]  = in_beat.lane_in_9;
  assign stg_lanes[0][10] = in_beat.lane_in_10;
  assign stg_lanes[0][11] = in_beat.lane_in_11;

  // ---- round pipeline ----
  // Stage k holds constant k; it is active when k is among the last
  // rounds_sat positions, i.e. k + rounds_sat >= 12.
  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
    round_sel_t sel;

    assign sel.active = ((RCNT_W+1)'(k) + {1'b0, rounds_sat}) >= (RCNT_W+1)'(NUM_ROUNDS);
    assign sel.rc     = RC_TABLE[k];

    xood_round_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .sel      (sel),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_lanes (stg_lanes[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_lanes (stg_lanes[k+1])
    );
  end

  // ---- output pack: the last stage register is the output register ----
  assign out_beat.valid        = stg_valid[NUM_ROUNDS];
  assign stg_ready[NUM_ROUNDS] = out_beat.ready;
  assign out_beat.lane_out_0   = stg_lanes[NUM_ROUNDS][0];
  assign out_beat.lane_out_1   = stg_lanes[NUM_ROUNDS][1];
  assign out_beat.lane_out_2   = stg_lanes[NUM_ROUNDS][2];
  assign out_beat.lane_out_3   = stg_lanes[NUM_ROUNDS][3];
  assign out_beat.lane_out_4   = stg_lanes[NUM_ROUNDS][4];
  assign out_beat.lane_out_5   = stg_lanes[NUM_ROUNDS][5];
  assign out_beat.lane_out_6   = stg_lanes[NUM_ROUNDS][6];
  assign out_beat.lane_out_7   = stg_lanes[NUM_ROUNDS][7];
  assign out_beat.lane_out_8   = stg_lanes[NUM_ROUNDS][8];
  assign out_beat.lane_out_9   = stg_lanes[NUM_ROUNDS][9];
  assign out_beat.lane_out_10  = stg_lanes[NUM_ROUNDS][10];
  assign out_beat.lane_out_11  = stg_lanes[NUM_ROUNDS][11];

endmodule

@@ rtl/xood_checker.sv @@
module xood_checker
  import xood_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input lane_t                 out_lane_0,
  input lane_t                 out_lane_11,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lane_0) && $stable(out_lane_11))
    else $error("stalled output beat changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a free output frees every stage back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // round_count reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[2] == REG_ROUND_COUNT)
    |=> (paddr[2] != REG_ROUND_COUNT) || (prdata[RCNT_W-1:0] == $past(pwdata[RCNT_W-1:0])))
    else $error("round_count readback mismatch");

endmodule

bind xoodoo_permutation_unit xood_checker u_xood_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_beat.ready),
  .out_valid   (out_beat.valid),
  .out_ready   (out_beat.ready),
  .out_lane_0  (out_beat.lane_out_0),
  .out_lane_11 (out_beat.lane_out_11),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
